/* rtl/pfe_pkg.sv */
// ============================================================================
// Postfix evaluator package
// Shared constants, character codes, status codes and the request and
// response structs that pass between the sequencer and the arithmetic unit.
// ============================================================================
package pfe_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ITER_W      = $clog2(DATA_W);
    localparam int SYM_W       = 8;

    localparam logic [SYM_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_DIVZERO   = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } alu_rsp_t;

endpackage

/* rtl/pfe_alu.sv */
// ============================================================================
// Postfix evaluator arithmetic unit
// Add and subtract in one step, multiply by shift and add, and signed
// division by restoring steps on magnitudes, one bit per cycle.
// ============================================================================
module pfe_alu import pfe_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  alu_req_t          req,
    input  logic [DATA_W-1:0] opa,
    input  logic [DATA_W-1:0] opb,
    output alu_rsp_t          rsp
);

    typedef enum logic [1:0] {A_IDLE, A_RUN, A_FIN} alu_state_t;

    alu_state_t        state_reg, state_next;
    alu_op_t           op_reg, op_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0] y_reg, y_next;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;

    always_comb begin
        mag_a   = opa[DATA_W-1] ? (~opa + 1'b1) : opa;
        mag_b   = opb[DATA_W-1] ? (~opb + 1'b1) : opb;
        shifted = {acc_reg, y_reg[DATA_W-1]};
        diff    = shifted - {1'b0, x_reg};

        state_next = state_reg;
        op_next    = op_reg;
        iter_next  = iter_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;

        unique case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    op_next   = req.op;
                    iter_next = ITER_W'(DATA_W - 1);
                    neg_next  = 1'b0;
                    unique case (req.op)
                        ALU_ADD: begin
                            acc_next   = opa + opb;
                            state_next = A_FIN;
                        end
                        ALU_SUB: begin
                            acc_next   = opa - opb;
                            state_next = A_FIN;
                        end
                        ALU_MUL: begin
                            acc_next   = '0;
                            x_next     = opa;
                            y_next     = opb;
                            state_next = A_RUN;
                        end
                        default: begin
                            acc_next   = '0;
                            x_next     = mag_b;
                            y_next     = mag_a;
                            neg_next   = opa[DATA_W-1] ^ opb[DATA_W-1];
                            state_next = A_RUN;
                        end
                    endcase
                end
            end
            A_RUN: begin
                if (op_reg == ALU_MUL) begin
                    if (y_reg[0]) begin
                        acc_next = acc_reg + x_reg;
                    end
                    x_next = {x_reg[DATA_W-2:0], 1'b0};
                    y_next = {1'b0, y_reg[DATA_W-1:1]};
                end else begin
                    if (!diff[DATA_W]) begin
                        acc_next = diff[DATA_W-1:0];
                        y_next   = {y_reg[DATA_W-2:0], 1'b1};
                    end else begin
                        acc_next = shifted[DATA_W-1:0];
                        y_next   = {y_reg[DATA_W-2:0], 1'b0};
                    end
                end
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0) begin
                    state_next = A_FIN;
                end
            end
            A_FIN: begin
                state_next = A_IDLE;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg   <= op_next;
        iter_reg <= iter_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
    end

    // The quotient sits in the shift register; its sign is applied on the way out.
    assign rsp.done   = (state_reg == A_FIN);
    assign rsp.result = (op_reg == ALU_DIV) ? (neg_reg ? (~y_reg + 1'b1) : y_reg) : acc_reg;

endmodule

/* rtl/postfix_expression_evaluator_core.sv */
// ============================================================================
// Postfix expression evaluator core
// Takes one character per beat and reports one value and status per '='.
// ============================================================================
// Flow for a user: a digit, a space, an unknown character or any character
// after an error is taken at once. A '+' or '-' holds the input while the
// operands are read from the stack, pass once through the arithmetic unit and
// the result is written back. A '*' or '/' holds it longer, because the single
// shared arithmetic unit works one bit per cycle over 32 iterations. A '='
// reads the stack and then waits for the result register to be free. The
// result register lets further characters be taken while a result waits to
// be read. The operand stack is a small memory with two registered read ports
// and one write port; it needs no clearing, since only entries below the
// count are ever read.
module postfix_expression_evaluator_core import pfe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] value, [33:32] status, rest zero
);

    typedef enum logic [2:0] {S_IDLE, S_FETCH, S_CALC, S_EQ, S_EMIT} state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    status_t           err_reg, err_next;
    alu_op_t           op_reg, op_next;
    logic [DATA_W-1:0] pend_value_reg, pend_value_next;
    status_t           pend_status_reg, pend_status_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_value_reg, m_value_next;
    status_t           m_status_reg, m_status_next;

    // Operand stack and its ports.
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_top_addr;
    logic [ADDR_W-1:0] rd_low_addr;
    logic [DATA_W-1:0] rd_top_reg;
    logic [DATA_W-1:0] rd_low_reg;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic             accept;
    logic [SYM_W-1:0] sym;
    logic             is_digit;
    logic             is_oper;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_m2;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign sym      = s_tdata;
    assign is_digit = (sym >= CH_ZERO) && (sym <= CH_NINE);
    assign is_oper  = (sym == CH_PLUS) || (sym == CH_MINUS) ||
                      (sym == CH_STAR) || (sym == CH_SLASH);
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign cnt_m2   = cnt_reg - CNT_W'(2);

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        err_next         = err_reg;
        op_next          = op_reg;
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;
        m_valid_next     = m_valid_reg;
        m_value_next     = m_value_reg;
        m_status_next    = m_status_reg;

        wr_en       = 1'b0;
        wr_addr     = cnt_reg[ADDR_W-1:0];
        wr_data     = DATA_W'(sym - CH_ZERO);
        rd_en       = 1'b0;
        rd_top_addr = cnt_m1[ADDR_W-1:0];
        rd_low_addr = cnt_m2[ADDR_W-1:0];
        alu_req     = '{start: 1'b0, op: op_reg};

        // The result register drains independently of the sequencer.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (sym == CH_EQ) begin
                        // The expression ends here; the stack and the error clear at once.
                        cnt_next = '0;
                        err_next = ST_OK;
                        if (err_reg == ST_OK && cnt_reg == CNT_W'(1)) begin
                            rd_en       = 1'b1;
                            rd_low_addr = '0;
                            state_next  = S_EQ;
                        end else begin
                            pend_value_next  = '0;
                            pend_status_next = (err_reg == ST_OK) ? ST_MALFORMED : err_reg;
                            state_next       = S_EMIT;
                        end
                    end else if (err_reg != ST_OK || sym == CH_SPACE) begin
                        // Ignored until the next '='.
                    end else if (is_digit) begin
                        if (cnt_reg >= CNT_W'(STACK_DEPTH)) begin
                            err_next = ST_OVERFLOW;
                        end else begin
                            wr_en    = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end else if (!is_oper) begin
                        err_next = ST_MALFORMED;
                    end else if (cnt_reg < CNT_W'(2)) begin
                        err_next = ST_MALFORMED;
                    end else begin
                        rd_en      = 1'b1;
                        state_next = S_FETCH;
                        case (sym)
                            CH_PLUS:  op_next = ALU_ADD;
                            CH_MINUS: op_next = ALU_SUB;
                            CH_STAR:  op_next = ALU_MUL;
                            default:  op_next = ALU_DIV;
                        endcase
                    end
                end
            end
            S_FETCH: begin
                // The right operand is on top; a zero divisor leaves the stack as it is.
                if (op_reg == ALU_DIV && rd_top_reg == '0) begin
                    err_next   = ST_DIVZERO;
                    state_next = S_IDLE;
                end else begin
                    alu_req.start = 1'b1;
                    state_next    = S_CALC;
                end
            end
            S_CALC: begin
                if (alu_rsp.done) begin
                    wr_en      = 1'b1;
                    wr_addr    = cnt_m2[ADDR_W-1:0];
                    wr_data    = alu_rsp.result;
                    cnt_next   = cnt_m1;
                    state_next = S_IDLE;
                end
            end
            S_EQ: begin
                pend_value_next  = rd_low_reg;
                pend_status_next = ST_OK;
                state_next       = S_EMIT;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = pend_value_reg;
                    m_status_next = pend_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg          <= op_next;
        pend_value_reg  <= pend_value_next;
        pend_status_reg <= pend_status_next;
        m_value_reg     <= m_value_next;
        m_status_reg    <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_top_reg <= stack_mem[rd_top_addr];
            rd_low_reg <= stack_mem[rd_low_addr];
        end
    end

    pfe_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (rd_low_reg),
        .opb     (rd_top_reg),
        .rsp     (alu_rsp)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_status_reg, m_value_reg};

`ifndef SYNTH
    // The count never passes the depth of the stack.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // The arithmetic unit finishes only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |-> state_reg == S_CALC)
        else $error("arithmetic result with no waiting operator");

    // A terminator always leaves an empty stack and no error behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && sym == CH_EQ) |=> (cnt_reg == '0 && err_reg == ST_OK))
        else $error("expression state not cleared after terminator");

    // A failed expression never reports a nonzero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |-> m_value_reg == '0)
        else $error("value reported with an error status");
`endif

endmodule
